// ===== design/next_lexicographic_permutation_top_defines.svh =====
// Assertion macros for the next-permutation engine.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NLP_ASSERT_IMP(lbl, ante, cons, msg)
`define NLP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/nlp_pkg.sv =====
// Shared types and constants for the next-permutation engine.
package nlp_pkg;

  localparam int NLP_MAX_LEN     = 16;
  localparam int NLP_VALUE_WIDTH = 8;
  localparam int NLP_DATA_W      = 8;
  localparam int NLP_IDX_W       = 4;
  localparam int NLP_LEN_W       = 5;
  localparam logic [NLP_LEN_W-1:0] NLP_LEN_RESET = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_SUCC,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SUB_NONE,
    SUB_SV,
    SUB_PV
  } sub_t;

  typedef struct packed {
    logic [NLP_DATA_W-1:0] value;
    logic [NLP_IDX_W-1:0]  index;
    logic                  found;
    logic                  last;
  } res_t;

endpackage

// ===== design/nlp_bank.sv =====
// One element bank: single write port, registered read port.
module nlp_bank #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nlp_out.sv =====
// Two-entry result queue driving the output stream.
module nlp_out import nlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  res_t        push_res,
  output logic [1:0]  cnt,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // element_value_out[7:0], element_index[11:8], zero
  output logic        out_tuser,  // found_next
  output logic        out_tlast
);

  res_t       ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  res_t       head;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign cnt        = cnt_r;
  assign head       = ent_r[rptr_r];
  assign out_tdata  = {4'b0000, head.index, head.value};
  assign out_tuser  = head.found;
  assign out_tlast  = head.last;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_res;
    end
  end

endmodule

// ===== design/nlp_ctrl.sv =====
// Sequencer: pivot scan, successor scan and permuted copy-out between banks.
`include "next_lexicographic_permutation_top_defines.svh"
module nlp_ctrl import nlp_pkg::*; #(
  parameter int MAX_LEN     = NLP_MAX_LEN,
  parameter int VALUE_WIDTH = NLP_VALUE_WIDTH,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int W1 = LW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_cmd,
  input  logic [NLP_DATA_W-1:0]  in_value,
  input  logic                   cfg_we,
  input  logic [NLP_LEN_W-1:0]   cfg_wdata,
  output logic                   wr_en,
  output logic                   wr_bank,
  output logic [AW-1:0]          wr_addr,
  output logic [VALUE_WIDTH-1:0] wr_data,
  output logic [AW-1:0]          rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_data_a,
  input  logic [VALUE_WIDTH-1:0] rd_data_b,
  output logic                   push,
  output res_t                   push_res,
  input  logic [1:0]             out_cnt,
  input  logic                   out_pop
);

  state_t                 state_r, state_nxt;
  logic [NLP_LEN_W-1:0]   len_r, len_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [MAX_LEN-1:0]     sel_r, sel_nxt;
  logic [LW-1:0]          n_r, n_nxt;
  logic [AW-1:0]          iss_r, iss_nxt;
  logic                   iss_on_r, iss_on_nxt;
  logic                   rq_v_r, rq_v_nxt;
  logic [AW-1:0]          rq_addr_r, rq_addr_nxt;
  logic                   rq_bank_r, rq_bank_nxt;
  sub_t                   rq_sub_r, rq_sub_nxt;
  logic [VALUE_WIDTH-1:0] prev_r, prev_nxt;
  logic                   prev_v_r, prev_v_nxt;
  logic [AW-1:0]          piv_r, piv_nxt;
  logic [VALUE_WIDTH-1:0] pv_r, pv_nxt;
  logic [VALUE_WIDTH-1:0] sv_r, sv_nxt;
  logic [AW-1:0]          succ_r, succ_nxt;
  logic                   found_r, found_nxt;

  logic                   load_acc, step_acc;
  logic [LW-1:0]          n_use;
  logic [AW-1:0]          last_pos;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   piv_hit, piv_end, succ_hit;
  logic                   credit, em_issue, em_arr, em_last, em_done, sc_issue;
  logic [AW-1:0]          r_map;
  sub_t                   sub;
  logic [VALUE_WIDTH-1:0] em_val;
  logic [MAX_LEN-1:0]     used_mask;

  assign load_acc = in_tvalid && in_tready && !in_cmd;
  assign step_acc = in_tvalid && in_tready && in_cmd;
  assign last_pos = AW'(n_r - LW'(1));
  assign rd_val   = rq_bank_r ? rd_data_b : rd_data_a;

  always_comb begin
    if (len_r == '0) begin
      n_use = LW'(1);
    end else if (int'(len_r) > MAX_LEN) begin
      n_use = LW'(MAX_LEN);
    end else begin
      n_use = LW'(len_r);
    end
  end

  assign piv_hit  = (state_r == ST_PIVOT) && rq_v_r && prev_v_r && (rd_val < prev_r);
  assign piv_end  = (state_r == ST_PIVOT) && rq_v_r && !piv_hit && (rq_addr_r == '0);
  assign succ_hit = (state_r == ST_SUCC) && rq_v_r && (rd_val > pv_r);
  assign sc_issue = ((state_r == ST_PIVOT) || (state_r == ST_SUCC)) && iss_on_r;
  assign credit   = (int'(out_cnt) + int'(rq_v_r) - int'(out_pop)) < 2;
  assign em_issue = (state_r == ST_EMIT) && iss_on_r && credit;
  assign em_arr   = (state_r == ST_EMIT) && rq_v_r;
  assign em_last  = (rq_addr_r == last_pos);
  assign em_done  = em_arr && em_last;

  // suffix after the pivot comes out reversed, with the successor swapped in
  always_comb begin
    r_map = iss_r;
    sub   = SUB_NONE;
    if (found_r && (iss_r > piv_r)) begin
      r_map = AW'(W1'(piv_r) + W1'(n_r) - W1'(iss_r));
      if (r_map == succ_r) begin
        sub = SUB_PV;
      end
    end else if (found_r && (iss_r == piv_r)) begin
      sub = SUB_SV;
    end
  end

  always_comb begin
    case (rq_sub_r)
      SUB_SV:  em_val = sv_r;
      SUB_PV:  em_val = pv_r;
      default: em_val = rd_val;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      used_mask[i] = (i < int'(n_r));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (step_acc) begin
          state_nxt = (n_use < LW'(2)) ? ST_EMIT : ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        if (piv_hit) begin
          state_nxt = ST_SUCC;
        end else if (piv_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SUCC: begin
        if (succ_hit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    rd_addr   = (state_r == ST_EMIT) ? r_map : iss_r;
    wr_en     = load_acc || em_arr;
    wr_addr   = em_arr ? rq_addr_r : wp_r;
    wr_bank   = em_arr ? ~sel_r[rq_addr_r] : sel_r[wp_r];
    wr_data   = em_arr ? em_val : VALUE_WIDTH'(in_value);
    push      = em_arr;
    push_res.value = NLP_DATA_W'(em_val);
    push_res.index = NLP_IDX_W'(rq_addr_r);
    push_res.found = found_r;
    push_res.last  = em_last;
  end

  // datapath registers
  always_comb begin
    len_nxt     = cfg_we ? cfg_wdata : len_r;
    wp_nxt      = wp_r;
    sel_nxt     = sel_r;
    n_nxt       = n_r;
    iss_nxt     = iss_r;
    iss_on_nxt  = iss_on_r;
    rq_v_nxt    = 1'b0;
    rq_addr_nxt = rq_addr_r;
    rq_bank_nxt = rq_bank_r;
    rq_sub_nxt  = rq_sub_r;
    prev_nxt    = prev_r;
    prev_v_nxt  = prev_v_r;
    piv_nxt     = piv_r;
    pv_nxt      = pv_r;
    sv_nxt      = sv_r;
    succ_nxt    = succ_r;
    found_nxt   = found_r;
    case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          wp_nxt = (wp_r == AW'(MAX_LEN - 1)) ? '0 : wp_r + AW'(1);
        end
        if (step_acc) begin
          wp_nxt     = '0;
          n_nxt      = n_use;
          iss_nxt    = (n_use < LW'(2)) ? '0 : AW'(n_use - LW'(1));
          iss_on_nxt = 1'b1;
          prev_v_nxt = 1'b0;
          found_nxt  = 1'b0;
        end
      end
      ST_PIVOT, ST_SUCC: begin
        if (sc_issue) begin
          rq_v_nxt    = 1'b1;
          rq_addr_nxt = iss_r;
          rq_bank_nxt = sel_r[iss_r];
          if (iss_r == '0) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r - AW'(1);
          end
        end
        if (piv_hit) begin
          piv_nxt    = rq_addr_r;
          pv_nxt     = rd_val;
          found_nxt  = 1'b1;
          iss_nxt    = last_pos;
          iss_on_nxt = 1'b1;
          rq_v_nxt   = 1'b0;
        end else if (piv_end || succ_hit) begin
          iss_nxt    = '0;
          iss_on_nxt = 1'b1;
          rq_v_nxt   = 1'b0;
        end else if ((state_r == ST_PIVOT) && rq_v_r) begin
          prev_nxt   = rd_val;
          prev_v_nxt = 1'b1;
        end
        if (succ_hit) begin
          succ_nxt = rq_addr_r;
          sv_nxt   = rd_val;
        end
      end
      ST_EMIT: begin
        if (em_issue) begin
          rq_v_nxt    = 1'b1;
          rq_addr_nxt = iss_r;
          rq_bank_nxt = sel_r[r_map];
          rq_sub_nxt  = sub;
          if (iss_r == last_pos) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + AW'(1);
          end
        end
        if (em_done) begin
          sel_nxt = sel_r ^ used_mask;
        end
      end
      default: begin
        iss_on_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= NLP_LEN_RESET;
      wp_r     <= '0;
      sel_r    <= '0;
      iss_on_r <= 1'b0;
      rq_v_r   <= 1'b0;
      prev_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      wp_r     <= wp_nxt;
      sel_r    <= sel_nxt;
      iss_on_r <= iss_on_nxt;
      rq_v_r   <= rq_v_nxt;
      prev_v_r <= prev_v_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    iss_r     <= iss_nxt;
    rq_addr_r <= rq_addr_nxt;
    rq_bank_r <= rq_bank_nxt;
    rq_sub_r  <= rq_sub_nxt;
    prev_r    <= prev_nxt;
    piv_r     <= piv_nxt;
    pv_r      <= pv_nxt;
    sv_r      <= sv_nxt;
    succ_r    <= succ_nxt;
  end

  `NLP_ASSERT_IMP(a_no_write_in_scan, (state_r == ST_PIVOT) || (state_r == ST_SUCC), !wr_en, "bank written during a scan")
  `NLP_ASSERT_IMP(a_push_room, push, out_cnt != 2'd2, "result pushed into a full queue")
  `NLP_ASSERT_NXT(a_last_idle, push && push_res.last, state_r == ST_IDLE, "run did not end on its last element")
  `NLP_ASSERT_IMP(a_succ_right, (state_r == ST_SUCC) && rq_v_r, rq_addr_r > piv_r, "successor scan passed the pivot")

endmodule

// ===== design/next_lexicographic_permutation_top.sv =====
// Top level of the next lexicographic permutation engine.
// Input stream in_*: in_tuser = 0 loads in_tdata into the element at the write
// pointer, which wraps after MAX_LEN loads; in_tuser = 1 is a step request.
// A step permutes the first array_length elements (cfg_we/cfg_wdata, 1..16,
// 0 counts as 1) into their next lexicographic order, clears the write
// pointer and sends one result per element in index order on out_*:
// value and index in out_tdata, found flag in out_tuser, out_tlast on the end.
// in_tready stays high during loads, so loads can run back to back.
// A step with two or more elements runs a pivot scan from the end, a
// successor scan once a pivot is found and then the copy-out, which
// writes the permuted elements into the other bank; all of them read the
// element banks through one shared read address. With no pivot the
// elements come out unchanged with the found flag clear.
// in_tready is low from a step request until its last result sits in the
// output queue; a stalled receiver pauses the copy-out with no loss.
// Reset clears the write pointer, sets array_length to 4 and empties the
// output queue; element contents are undefined until loaded.
module next_lexicographic_permutation_top import nlp_pkg::*; #(
  parameter int MAX_LEN     = NLP_MAX_LEN,
  parameter int VALUE_WIDTH = NLP_VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // element_value[7:0]
  input  logic                 in_tuser,   // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // element_value_out[7:0], element_index[11:8], zero
  output logic                 out_tuser,  // found_next
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [NLP_LEN_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_LEN);

  logic                   wr_en, wr_bank;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;
  logic                   push, out_pop;
  res_t                   push_res;
  logic [1:0]             out_cnt;

  nlp_ctrl #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .push      (push),
    .push_res  (push_res),
    .out_cnt   (out_cnt),
    .out_pop   (out_pop)
  );

  nlp_bank #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_WIDTH)
  ) u_bank_a (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data_a)
  );

  nlp_bank #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_WIDTH)
  ) u_bank_b (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data_b)
  );

  nlp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (push_res),
    .cnt        (out_cnt),
    .pop        (out_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
